// File: rtl/tpt_pkg.sv
package tpt_pkg;

  // table size default
  localparam int unsigned DepthDef = 64;

  localparam int unsigned HashW  = 256;
  localparam int unsigned PeerW  = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned OpW    = 3;

  // request opcodes
  localparam logic [OpW-1:0] OP_ADD         = 3'd0;
  localparam logic [OpW-1:0] OP_LOOKUP_PAIR = 3'd1;
  localparam logic [OpW-1:0] OP_LOOKUP_HASH = 3'd2;
  localparam logic [OpW-1:0] OP_TAKE        = 3'd3;
  localparam logic [OpW-1:0] OP_PRUNE       = 3'd4;

  // one table slot as stored in the entry memory
  typedef struct packed {
    logic              valid;
    logic [HashW-1:0]  hash;
    logic [PeerW-1:0]  peer;
    logic [StampW-1:0] stamp;
  } tpt_entry_t;

  // captured request
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [HashW-1:0]  hash;
    logic [PeerW-1:0]  peer;
    logic [StampW-1:0] now;
  } tpt_req_t;

  // compare unit results for one slot
  typedef struct packed {
    logic hash_hit;
    logic pair_hit;
    logic expired;
    logic older;
  } tpt_cmp_t;

endpackage

// File: rtl/tpt_entry_ram.sv
module tpt_entry_ram
  import tpt_pkg::*;
#(
  parameter int unsigned Depth = DepthDef,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  tpt_entry_t      wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output tpt_entry_t      rd_data_o
);

  tpt_entry_t mem_q [Depth];
  tpt_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/tpt_cmp_unit.sv
module tpt_cmp_unit
  import tpt_pkg::*;
(
  input  tpt_entry_t        entry_i,
  input  tpt_req_t          req_i,
  input  logic [StampW-1:0] ttl_i,
  input  logic [StampW-1:0] min_stamp_i,
  output tpt_cmp_t          res_o
);

  logic [StampW:0] age;
  logic            hash_eq;

  assign hash_eq = (entry_i.hash == req_i.hash);

  // signed age, now minus stamp, one bit wider
  assign age = {1'b0, req_i.now} - {1'b0, entry_i.stamp};

  assign res_o.hash_hit = entry_i.valid && hash_eq;
  assign res_o.pair_hit = entry_i.valid && hash_eq && (entry_i.peer == req_i.peer);
  assign res_o.expired  = entry_i.valid && !age[StampW] && (age[StampW-1:0] > ttl_i);
  assign res_o.older    = (entry_i.stamp < min_stamp_i);

endmodule

// File: rtl/timestamped_pair_table.sv
// timestamped_pair_table: table of (256-bit hash, peer, time stamp) slots
// input stream: s_axis carries one request; tuser holds the opcode (add or touch,
// lookup pair, lookup hash, take pair, prune), tdata holds the hash words, peer
// and current time. output stream: m_axis returns one byte per request, bit 0 is
// the found flag. cfg_we_i / cfg_wdata_i write the ttl register used by prune.
// each request with a known opcode scans the slots one per cycle through a single
// compare unit fed by the one read port of the entry memory; add without a match
// then writes the chosen slot in a fill step, and a hit on add, lookup or take
// ends the scan early. unused opcodes skip the scan and answer straight from the
// done state. one request is worked on at a time: the next one is taken the cycle
// after the result is loaded. after reset the block walks the entry memory once
// to clear it, with tready low; the ttl register resets to 600 and can be written
// meanwhile. a finished result sits in the output register until taken; the
// next request is accepted meanwhile, but its own result waits while the
// receiver stalls.
module timestamped_pair_table
  import tpt_pkg::*;
#(
  parameter int unsigned TableDepth = DepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request channel
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // hash_word0, hash_word1, hash_word2, hash_word3, peer_id, now_secs
  input  logic [319:0] s_axis_tdata_i,
  // opcode
  input  logic [2:0]   s_axis_tuser_i,
  // result channel
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // found, then zero padding
  output logic [7:0]   m_axis_tdata_o,
  // ttl register
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(TableDepth);
  localparam logic [StampW-1:0] TtlReset = 32'd600;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [IdxW-1:0]   clr_q;
  logic [CntW-1:0]   rd_cnt_q;
  logic              p_vld_q;
  logic [IdxW-1:0]   p_idx_q;
  logic              res_q;
  logic              free_found_q;
  logic [IdxW-1:0]   free_idx_q;
  logic              min_have_q;
  logic [StampW-1:0] min_stamp_q;
  logic [IdxW-1:0]   min_idx_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [StampW-1:0] ttl_q;
  tpt_req_t          req_q;

  logic              in_acc;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  tpt_entry_t        wr_data;
  tpt_entry_t        rd_entry;
  tpt_cmp_t          cmp;
  logic              ev;
  logic              hit;
  logic              last;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_found_q};

  // ttl register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TtlReset;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.op   <= s_axis_tuser_i;
      req_q.hash <= s_axis_tdata_i[255:0];
      req_q.peer <= s_axis_tdata_i[287:256];
      req_q.now  <= s_axis_tdata_i[319:288];
    end
  end

  // entry memory
  tpt_entry_ram #(
    .Depth(TableDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_entry)
  );

  // shared compare unit, one slot per cycle
  tpt_cmp_unit u_cmp (
    .entry_i    (rd_entry),
    .req_i      (req_q),
    .ttl_i      (ttl_q),
    .min_stamp_i(min_stamp_q),
    .res_o      (cmp)
  );

  // read side of the scan
  assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < CntEnd);
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  // evaluation of the slot that just came back
  assign ev   = (state_q == ST_SCAN) && p_vld_q;
  assign last = ev && (p_idx_q == LastIdx);

  always_comb begin
    hit = 1'b0;
    if (ev) begin
      if (req_q.op == OP_ADD || req_q.op == OP_LOOKUP_PAIR || req_q.op == OP_TAKE) begin
        hit = cmp.pair_hit;
      end else if (req_q.op == OP_LOOKUP_HASH) begin
        hit = cmp.hash_hit;
      end
    end
  end

  // write side: clearing pass, touch, take, prune, fill
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx_q;
    wr_data = rd_entry;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      ST_SCAN: begin
        if (ev) begin
          if (req_q.op == OP_ADD && cmp.pair_hit) begin
            wr_en         = 1'b1;
            wr_data.stamp = req_q.now;
          end else if (req_q.op == OP_TAKE && cmp.pair_hit) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
          end else if (req_q.op == OP_PRUNE && cmp.expired) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
          end
        end
      end
      ST_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = free_found_q ? free_idx_q : min_idx_q;
        wr_data.valid = 1'b1;
        wr_data.hash  = req_q.hash;
        wr_data.peer  = req_q.peer;
        wr_data.stamp = req_q.now;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      clr_q        <= '0;
      rd_cnt_q     <= '0;
      p_vld_q      <= 1'b0;
      p_idx_q      <= '0;
      res_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      min_have_q   <= 1'b0;
      min_stamp_q  <= '0;
      min_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
    end else begin
      p_vld_q <= rd_en;
      p_idx_q <= rd_addr;
      // result taken while no new one is loaded
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LastIdx) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            rd_cnt_q     <= '0;
            res_q        <= 1'b0;
            free_found_q <= 1'b0;
            min_have_q   <= 1'b0;
            if (s_axis_tuser_i == OP_ADD || s_axis_tuser_i == OP_LOOKUP_PAIR ||
                s_axis_tuser_i == OP_LOOKUP_HASH || s_axis_tuser_i == OP_TAKE ||
                s_axis_tuser_i == OP_PRUNE) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (ev) begin
            // first empty slot and oldest stamp for a later fill
            if (!rd_entry.valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= p_idx_q;
            end
            if (!min_have_q || cmp.older) begin
              min_have_q  <= 1'b1;
              min_stamp_q <= rd_entry.stamp;
              min_idx_q   <= p_idx_q;
            end
          end
          if (hit) begin
            res_q   <= 1'b1;
            state_q <= ST_DONE;
          end else if (last) begin
            state_q <= (req_q.op == OP_ADD) ? ST_FILL : ST_DONE;
          end
        end
        ST_FILL: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_found_q <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  // a request is taken only from idle, so the next cycle is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("request accepted while busy");

  // prune never reports a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && req_q.op == OP_PRUNE) |-> !res_q)
    else $error("prune reported found");

  // scan read counter stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CntEnd)
    else $error("scan counter beyond table depth");

  // memory writes stay within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr <= LastIdx))
    else $error("entry write out of range");

  // a fill always follows a full scan of an add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (req_q.op == OP_ADD && $past(last)))
    else $error("fill without a completed add scan");

endmodule
